[hw/rtl/hbtb_pkg.sv]
// Shared types and constants for the height band texture blend.
// Used by every module in hw/rtl; depends on nothing.
package hbtb_pkg;

	localparam int unsigned LANES     = 4;
	localparam int unsigned HFRAC     = 6;
	localparam int unsigned DIV_BITS  = 17;
	localparam int unsigned HS_W      = 18;
	localparam int unsigned ARITH_W   = 22;
	localparam int unsigned PROD_W    = DIV_BITS + 8;
	localparam int unsigned SUM_W     = PROD_W + 2;
	localparam int unsigned LATENCY   = DIV_BITS + 4;

	localparam logic [1:0] REG_MIN_HEIGHT = 2'd0;
	localparam logic [1:0] REG_MAX_HEIGHT = 2'd1;
	localparam logic [1:0] REG_TILE_COUNT = 2'd2;

	typedef struct packed {
		logic [PROD_W-1:0] r;
		logic [PROD_W-1:0] g;
		logic [PROD_W-1:0] b;
	} prod_t;

	// Clamp the tile count register to 1..LANES.
	function automatic logic [2:0] eff_tiles(input logic [2:0] cnt);
		logic [2:0] res;
		res = cnt;
		if (cnt == 3'd0) begin
			res = 3'd1;
		end else if (cnt > 3'(LANES)) begin
			res = 3'(LANES);
		end
		return res;
	endfunction

endpackage

[hw/rtl/hbtb_front.sv]
// Front end: scales the height and works out each tile's weight numerator
// and divisor. Depends on hbtb_pkg.
module hbtb_front (
	input  logic                                 clk,
	input  logic [15:0]                          height,
	input  logic [3:0][23:0]                     colors,
	input  logic [15:0]                          min_height,
	input  logic [15:0]                          max_height,
	input  logic [2:0]                           tile_count,
	output logic [hbtb_pkg::LANES-1:0][hbtb_pkg::DIV_BITS-1:0] num_s2,
	output logic [hbtb_pkg::LANES-1:0][hbtb_pkg::DIV_BITS-1:0] den_s2,
	output logic [3:0][23:0]                     col_s2
);

	logic [2:0]                             t_eff;
	logic [hbtb_pkg::HS_W-1:0]              hs_s1;
	logic [3:0][23:0]                       col_s1;
	logic signed [hbtb_pkg::ARITH_W-1:0]    d;
	logic signed [hbtb_pkg::ARITH_W-1:0]    one_t;
	logic signed [hbtb_pkg::ARITH_W-1:0]    hs;

	assign t_eff = hbtb_pkg::eff_tiles(tile_count);
	assign d     = hbtb_pkg::ARITH_W'($signed({1'b0, max_height}))
		- hbtb_pkg::ARITH_W'($signed({1'b0, min_height}));
	assign one_t = $signed(hbtb_pkg::ARITH_W'(t_eff) << hbtb_pkg::HFRAC);
	assign hs    = $signed(hbtb_pkg::ARITH_W'(hs_s1));

	// Scale the height by the tile count so band edges stay exact.
	always_ff @(posedge clk) begin
		hs_s1  <= hbtb_pkg::HS_W'(height * t_eff);
		col_s1 <= colors;
	end

	// Per lane: locate the height in the band and pick the slope.
	for (genvar i = 0; i < hbtb_pkg::LANES; i++) begin : g_lane
		logic signed [hbtb_pkg::ARITH_W-1:0] lo, pk, hi, num, den;
		logic                                ok;

		always_comb begin
			lo = $signed(hbtb_pkg::ARITH_W'(i)) * d;
			pk = $signed(hbtb_pkg::ARITH_W'(i + 1)) * d - one_t;
			hi = $signed(hbtb_pkg::ARITH_W'(i + 2)) * d - one_t;
			if (hs < pk) begin
				num = hs - lo;
				den = pk - lo;
			end else begin
				num = hi - hs;
				den = hi - pk;
			end
			ok = (hs >= lo) && (hs <= hi) && (den > 0) && (num >= 0)
				&& (3'(i) < t_eff);
		end

		// Hold an idle lane at zero weight.
		always_ff @(posedge clk) begin
			num_s2[i] <= ok ? num[hbtb_pkg::DIV_BITS-1:0] : '0;
			den_s2[i] <= ok ? den[hbtb_pkg::DIV_BITS-1:0] : hbtb_pkg::DIV_BITS'(1);
		end
	end

	always_ff @(posedge clk) begin
		col_s2 <= col_s1;
	end

endmodule

[hw/rtl/hbtb_lane.sv]
// One tile lane: pipelined restoring divider for the weight, then the
// weight times each colour channel. Depends on hbtb_pkg.
module hbtb_lane (
	input  logic                          clk,
	input  logic [hbtb_pkg::DIV_BITS-1:0] num,
	input  logic [hbtb_pkg::DIV_BITS-1:0] den,
	input  logic [23:0]                   color,
	output hbtb_pkg::prod_t               prod_s
);

	localparam int unsigned N = hbtb_pkg::DIV_BITS;

	logic [N:0]   rem_s [1:N-1];
	logic [N-1:0] den_s [1:N-1];
	logic [N-1:0] q_s   [1:N];
	logic [23:0]  col_s [1:N];

	// One quotient bit per stage, most significant first.
	for (genvar k = 0; k < N; k++) begin : g_step
		logic [N:0]   trial;
		logic [N-1:0] den_k;
		logic [N-1:0] q_k;
		logic [23:0]  col_k;
		logic         ge;
		if (k == 0) begin : g_first
			assign trial = {1'b0, num};
			assign den_k = den;
			assign q_k   = '0;
			assign col_k = color;
		end else begin : g_next
			assign trial = {rem_s[k][N-1:0], 1'b0};
			assign den_k = den_s[k];
			assign q_k   = q_s[k];
			assign col_k = col_s[k];
		end
		assign ge = trial >= {1'b0, den_k};

		// Carry the remainder and divisor to the next bit.
		if (k < N - 1) begin : g_carry
			always_ff @(posedge clk) begin
				rem_s[k+1] <= ge ? trial - {1'b0, den_k} : trial;
				den_s[k+1] <= den_k;
			end
		end

		always_ff @(posedge clk) begin
			q_s[k+1]   <= {q_k[N-2:0], ge};
			col_s[k+1] <= col_k;
		end
	end

	// Weight the channels.
	always_ff @(posedge clk) begin
		prod_s.r <= hbtb_pkg::PROD_W'(q_s[N] * col_s[N][23:16]);
		prod_s.g <= hbtb_pkg::PROD_W'(q_s[N] * col_s[N][15:8]);
		prod_s.b <= hbtb_pkg::PROD_W'(q_s[N] * col_s[N][7:0]);
	end

endmodule

[hw/rtl/hbtb_merge.sv]
// Merge stage: sums the lane products, truncates and saturates each
// channel. Depends on hbtb_pkg.
module hbtb_merge (
	input  logic                                    clk,
	input  hbtb_pkg::prod_t [hbtb_pkg::LANES-1:0]   prod,
	output logic [7:0]                              red_q,
	output logic [7:0]                              green_q,
	output logic [7:0]                              blue_q,
	output logic                                    ovf_q
);

	localparam logic [hbtb_pkg::SUM_W-1:0] LIMIT = hbtb_pkg::SUM_W'(255) << 16;

	logic [hbtb_pkg::SUM_W-1:0] sr, sg, sb;

	// Add the lanes.
	always_comb begin
		sr = '0;
		sg = '0;
		sb = '0;
		for (int i = 0; i < hbtb_pkg::LANES; i++) begin
			sr = sr + hbtb_pkg::SUM_W'(prod[i].r);
			sg = sg + hbtb_pkg::SUM_W'(prod[i].g);
			sb = sb + hbtb_pkg::SUM_W'(prod[i].b);
		end
	end

	// Saturate above 255.
	always_ff @(posedge clk) begin
		red_q   <= (sr > LIMIT) ? 8'hFF : sr[23:16];
		green_q <= (sg > LIMIT) ? 8'hFF : sg[23:16];
		blue_q  <= (sb > LIMIT) ? 8'hFF : sb[23:16];
		ovf_q   <= (sr > LIMIT) || (sg > LIMIT) || (sb > LIMIT);
	end

endmodule

[hw/rtl/height_band_texture_blend.sv]
// Top level of the height band texture blend.
// Depends on hbtb_pkg, hbtb_front, hbtb_lane and hbtb_merge.
//
// Usage:
//   Pulse start with height and the four tile colours to send one word.
//   busy is always low: a word is taken on every cycle start is high.
//   Each word gives one result word (red, green, blue, overflow) marked by
//   done for exactly one cycle.
//   Throughput is one word per cycle: front end two stages, a 17-stage
//   restoring divider per tile lane (one quotient bit per stage), one
//   multiply stage and one merge stage.
//   The receiver cannot stall; results are never held.
//   Configuration: cfg_we writes cfg_data to register cfg_index
//   (0 min_height, 1 max_height, 2 tile_count); write only while idle.
//   Reset (arst_n low) restores min 0, max 16384, four tiles and drops
//   every word in flight.
module height_band_texture_blend (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic [15:0] height,
	input  logic [23:0] tile0_color,
	input  logic [23:0] tile1_color,
	input  logic [23:0] tile2_color,
	input  logic [23:0] tile3_color,
	output logic        done,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic        overflow
);

	logic [15:0] min_height_q;
	logic [15:0] max_height_q;
	logic [2:0]  tile_count_q;
	logic [hbtb_pkg::LATENCY-1:0] vld_q;

	logic [hbtb_pkg::LANES-1:0][hbtb_pkg::DIV_BITS-1:0] num_s2, den_s2;
	logic [3:0][23:0]                                   col_s2;
	hbtb_pkg::prod_t [hbtb_pkg::LANES-1:0]              prod;

	assign busy = 1'b0;

	// Write configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_height_q <= 16'd0;
			max_height_q <= 16'd16384;
			tile_count_q <= 3'd4;
		end else if (cfg_we) begin
			case (cfg_index)
				hbtb_pkg::REG_MIN_HEIGHT: min_height_q <= cfg_data;
				hbtb_pkg::REG_MAX_HEIGHT: max_height_q <= cfg_data;
				hbtb_pkg::REG_TILE_COUNT: tile_count_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// Advance the valid marks alongside the data path.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[hbtb_pkg::LATENCY-2:0], start};
		end
	end

	assign done = vld_q[hbtb_pkg::LATENCY-1];

	hbtb_front u_front (
		.clk        (clk),
		.height     (height),
		.colors     ({tile3_color, tile2_color, tile1_color, tile0_color}),
		.min_height (min_height_q),
		.max_height (max_height_q),
		.tile_count (tile_count_q),
		.num_s2     (num_s2),
		.den_s2     (den_s2),
		.col_s2     (col_s2)
	);

	for (genvar i = 0; i < hbtb_pkg::LANES; i++) begin : g_lane
		hbtb_lane u_lane (
			.clk    (clk),
			.num    (num_s2[i]),
			.den    (den_s2[i]),
			.color  (col_s2[i]),
			.prod_s (prod[i])
		);
	end

	hbtb_merge u_merge (
		.clk     (clk),
		.prod    (prod),
		.red_q   (red),
		.green_q (green),
		.blue_q  (blue),
		.ovf_q   (overflow)
	);

endmodule
